>>> rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// shared constants and types of the telnet command filter
// ----------------------------------------------------------------------------
package tcf_pkg;

    // telnet command and option bytes
    localparam logic [7:0] TN_IAC      = 8'd255;
    localparam logic [7:0] TN_DONT     = 8'd254;
    localparam logic [7:0] TN_DO       = 8'd253;
    localparam logic [7:0] TN_WONT     = 8'd252;
    localparam logic [7:0] TN_WILL     = 8'd251;
    localparam logic [7:0] TN_SB       = 8'd250;
    localparam logic [7:0] TN_SE       = 8'd240;
    localparam logic [7:0] TN_OPT_ECHO = 8'd1;
    localparam logic [7:0] TN_OPT_SGA  = 8'd3;

    // result kinds on the output tuser
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // beat positions of a three-byte reply
    localparam logic [1:0] BEAT_IAC = 2'd0;
    localparam logic [1:0] BEAT_CMD = 2'd1;
    localparam logic [1:0] BEAT_OPT = 2'd2;

    // default depth of the action queue (at least 2)
    localparam int QUEUE_DEPTH_DEF = 2;

    // one action from the parser to the emitter
    typedef struct packed {
        logic       is_reply;  // 0: one data byte, 1: IAC cmd opt reply
        logic [7:0] cmd;       // reply command byte
        logic [7:0] byte_val;  // data byte, or option byte of a reply
    } action_t;

endpackage

>>> rtl/telnet_command_filter.sv
// ----------------------------------------------------------------------------
// telnet_command_filter
// telnet IAC filter: passes data bytes, swallows commands and subnegotiation,
// answers WILL and DO option requests with three-byte replies
// ----------------------------------------------------------------------------
// path: a data byte is registered in the action queue, then in the output
// stage before m_; throughput: one input byte per cycle while the queue is
// not full; a reply holds the emitter for three output beats, and with the
// default two-entry queue (QUEUE_DEPTH) a reply followed by more data stalls the input
// reset: synchronous active-low aresetn returns the parser to the data state
// and empties the queue and the output stage
module telnet_command_filter #(
    parameter int QUEUE_DEPTH = tcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] out_kind
    output logic       m_tlast    // out_last
);

    tcf_pkg::action_t act, head;
    logic             in_accept;
    logic             push, pop, q_empty, q_full;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    tcf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .rx_byte   (s_tdata),
        .act_push  (push),
        .act       (act)
    );

    tcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_act (act),
        .pop      (pop),
        .head_act (head),
        .empty    (q_empty),
        .full     (q_full),
        .count    (q_count)
    );

    tcf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // queue occupancy stays within its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("action queue overflow");

    // a non-final beat is always followed by another reply beat
    a_reply_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser)
        else $error("reply cut short");

    // a data byte is always a single final beat
    a_data_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("data byte without last");

    // a pop never happens on an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_count != '0)
        else $error("action queue underflow");

endmodule

>>> rtl/tcf_front.sv
// ----------------------------------------------------------------------------
// tcf_front
// byte parser: tracks the telnet command state and turns each received byte
// into nothing, a data action or a reply action
// ----------------------------------------------------------------------------
module tcf_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [7:0]       rx_byte,
    output logic             act_push,
    output tcf_pkg::action_t act
);

    localparam logic [2:0] ST_DATA  = 3'd0;
    localparam logic [2:0] ST_IAC   = 3'd1;
    localparam logic [2:0] ST_OPT   = 3'd2;
    localparam logic [2:0] ST_SB    = 3'd3;
    localparam logic [2:0] ST_SBIAC = 3'd4;

    localparam logic [1:0] PC_WILL = 2'd0;
    localparam logic [1:0] PC_DO   = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] pend_reg, pend_next;
    logic [7:0] cmd_diff;
    logic       act_valid;

    assign cmd_diff = rx_byte - tcf_pkg::TN_WILL;

    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        act_valid     = 1'b0;
        act.is_reply  = tcf_pkg::KIND_DATA;
        act.cmd       = tcf_pkg::TN_IAC;
        act.byte_val  = rx_byte;
        case (state_reg)
            ST_DATA: begin
                if (rx_byte == tcf_pkg::TN_IAC) begin
                    state_next = ST_IAC;
                end else begin
                    act_valid = 1'b1;
                end
            end
            ST_IAC: begin
                if (rx_byte == tcf_pkg::TN_IAC) begin
                    state_next = ST_DATA;
                    act_valid  = 1'b1;
                end else if (rx_byte >= tcf_pkg::TN_WILL) begin
                    // WILL..DONT, IAC already handled above
                    pend_next  = cmd_diff[1:0];
                    state_next = ST_OPT;
                end else if (rx_byte == tcf_pkg::TN_SB) begin
                    state_next = ST_SB;
                end else begin
                    state_next = ST_DATA;
                end
            end
            ST_OPT: begin
                state_next = ST_DATA;
                if (pend_reg == PC_WILL) begin
                    act_valid    = 1'b1;
                    act.is_reply = tcf_pkg::KIND_REPLY;
                    act.cmd      = (rx_byte == tcf_pkg::TN_OPT_ECHO ||
                                    rx_byte == tcf_pkg::TN_OPT_SGA) ?
                                   tcf_pkg::TN_DO : tcf_pkg::TN_DONT;
                end else if (pend_reg == PC_DO) begin
                    act_valid    = 1'b1;
                    act.is_reply = tcf_pkg::KIND_REPLY;
                    act.cmd      = (rx_byte == tcf_pkg::TN_OPT_SGA) ?
                                   tcf_pkg::TN_WILL : tcf_pkg::TN_WONT;
                end
            end
            ST_SB: begin
                if (rx_byte == tcf_pkg::TN_IAC) begin
                    state_next = ST_SBIAC;
                end
            end
            ST_SBIAC: begin
                state_next = (rx_byte == tcf_pkg::TN_SE) ? ST_DATA : ST_SB;
            end
            default: begin
                state_next = ST_DATA;
                act_valid  = 1'b1;
            end
        endcase
    end

    assign act_push = in_accept && act_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_DATA;
            pend_reg  <= PC_WILL;
        end else if (in_accept) begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

>>> rtl/tcf_queue.sv
// ----------------------------------------------------------------------------
// tcf_queue
// small action queue between the parser and the emitter
// ----------------------------------------------------------------------------
module tcf_queue #(
    parameter int DEPTH = tcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tcf_pkg::action_t push_act,
    input  logic             pop,
    output tcf_pkg::action_t head_act,
    output logic             empty,
    output logic             full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    tcf_pkg::action_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign count    = count_reg;
    assign head_act = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_act;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/tcf_back.sv
// ----------------------------------------------------------------------------
// tcf_back
// result emitter: plays one action out as one data byte or three reply bytes
// ----------------------------------------------------------------------------
module tcf_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  tcf_pkg::action_t q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    tcf_pkg::action_t cur_reg;
    logic             valid_reg;
    logic [1:0]       beat_reg;
    logic             take;
    logic             last_beat;

    assign last_beat = !cur_reg.is_reply || (beat_reg == tcf_pkg::BEAT_OPT);
    assign take      = valid_reg && m_tready;
    // reload when empty or when the final beat leaves
    assign q_pop     = !q_empty && (!valid_reg || (take && last_beat));

    always_comb begin
        case (beat_reg)
            tcf_pkg::BEAT_IAC: m_tdata = cur_reg.is_reply ? tcf_pkg::TN_IAC : cur_reg.byte_val;
            tcf_pkg::BEAT_CMD: m_tdata = cur_reg.cmd;
            default:           m_tdata = cur_reg.byte_val;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = cur_reg.is_reply;
    assign m_tlast  = last_beat;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= tcf_pkg::BEAT_IAC;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            beat_reg  <= tcf_pkg::BEAT_IAC;
        end else if (take) begin
            if (last_beat) begin
                valid_reg <= 1'b0;
                beat_reg  <= tcf_pkg::BEAT_IAC;
            end else begin
                beat_reg <= beat_reg + 1'b1;
            end
        end
    end

endmodule
